// ----- hdl/sidc_pkg.sv -----
// ----------------------------------------------------------------------------
// sidc_pkg
// Shared types and constants of the serial interface DMA controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sidc_pkg;

    // Byte copies issued when one transfer completes.
    localparam int XFER_BYTES = 64;
    localparam int IDX_W      = (XFER_BYTES > 1) ? $clog2(XFER_BYTES) : 1;

    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;
    localparam int DRAM_W     = 24;
    localparam int PIF_W      = 6;
    localparam int LAT_W      = 12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Bus commands carried in the input tuser.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Register offsets, decoded from the low six address bits on writes.
    localparam logic [5:0] OFF_DRAM_ADDR = 6'h00;
    localparam logic [5:0] OFF_FROM_PIF  = 6'h04;
    localparam logic [5:0] OFF_TO_PIF    = 6'h10;
    localparam logic [5:0] OFF_STATUS    = 6'h18;

    // Reads match the full offset.
    localparam logic [ADDR_W-1:0] STATUS_ADDR = 12'h018;

    // Configuration register indexes.
    localparam logic CFG_LAT_TO_PIF   = 1'b0;
    localparam logic CFG_LAT_FROM_PIF = 1'b1;

    localparam logic [LAT_W-1:0] LAT_TO_PIF_RST   = 12'd192;
    localparam logic [LAT_W-1:0] LAT_FROM_PIF_RST = 12'd1500;

    localparam int STATUS_BUSY_BIT = 0;
    localparam int STATUS_IRQ_BIT  = 12;

    // One queued job: either a single response or a whole copy burst.
    typedef struct packed {
        logic              burst;
        logic [DATA_W-1:0] read_data;
        logic              to_pif;
        logic [DRAM_W-1:0] base;
        logic              irq;
    } t_job;

    // Output payload as seen on the master tdata.
    typedef struct packed {
        logic [6:0]        pad;
        logic              irq;
        logic              check;
        logic [PIF_W-1:0]  pif_index;
        logic [DRAM_W-1:0] dram_addr;
        logic              to_pif;
        logic [DATA_W-1:0] read_data;
    } t_out_data;

endpackage

`default_nettype wire

// ----- hdl/sidc_front.sv -----
// ----------------------------------------------------------------------------
// sidc_front
// Decodes bus items, holds the DMA state and queues the resulting jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module sidc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_command,
    input  logic [sidc_pkg::ADDR_W-1:0]  i_address,
    input  logic [sidc_pkg::DATA_W-1:0]  i_write_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [sidc_pkg::LAT_W-1:0]   i_cfg_data,
    input  logic                         i_q_full,
    output logic                         o_push,
    output sidc_pkg::t_job               o_job
);

    logic [sidc_pkg::LAT_W-1:0]  r_lat_to, n_lat_to;
    logic [sidc_pkg::LAT_W-1:0]  r_lat_from, n_lat_from;
    logic [sidc_pkg::DRAM_W-1:0] r_base, n_base;
    logic                        r_busy, n_busy;
    logic                        r_irq, n_irq;
    logic                        r_dir, n_dir;
    logic [sidc_pkg::LAT_W-1:0]  r_count, n_count;

    logic accept;

    assign o_ready     = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !i_q_full;
    assign o_push      = accept;

    always_comb begin
        n_lat_to   = r_lat_to;
        n_lat_from = r_lat_from;
        n_base     = r_base;
        n_busy     = r_busy;
        n_irq      = r_irq;
        n_dir      = r_dir;
        n_count    = r_count;
        o_job      = '0;

        if (i_cfg_valid) begin
            if (i_cfg_index == sidc_pkg::CFG_LAT_TO_PIF) begin
                n_lat_to = i_cfg_data;
            end else begin
                n_lat_from = i_cfg_data;
            end
        end

        if (accept) begin
            unique case (i_command)
                sidc_pkg::CMD_WRITE: begin
                    unique case (i_address[5:0])
                        sidc_pkg::OFF_DRAM_ADDR: begin
                            n_base = i_write_data[sidc_pkg::DRAM_W-1:0];
                        end
                        sidc_pkg::OFF_FROM_PIF: begin
                            if (!r_busy) begin
                                n_busy  = 1'b1;
                                n_dir   = 1'b0;
                                n_count = r_lat_from;
                            end
                        end
                        sidc_pkg::OFF_TO_PIF: begin
                            if (!r_busy) begin
                                n_busy  = 1'b1;
                                n_dir   = 1'b1;
                                n_count = r_lat_to;
                            end
                        end
                        sidc_pkg::OFF_STATUS: begin
                            n_irq = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                sidc_pkg::CMD_READ: begin
                    if (i_address == sidc_pkg::STATUS_ADDR) begin
                        o_job.read_data[sidc_pkg::STATUS_BUSY_BIT] = r_busy;
                        o_job.read_data[sidc_pkg::STATUS_IRQ_BIT]  = r_irq;
                    end
                end
                sidc_pkg::CMD_TICK: begin
                    if (r_busy) begin
                        if (r_count <= sidc_pkg::LAT_W'(1)) begin
                            // Completion: the burst uses the base held right now.
                            n_count      = '0;
                            n_busy       = 1'b0;
                            n_irq        = 1'b1;
                            o_job.burst  = 1'b1;
                            o_job.to_pif = r_dir;
                            o_job.base   = r_base;
                        end else begin
                            n_count = r_count - sidc_pkg::LAT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            o_job.irq = n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_to   <= sidc_pkg::LAT_TO_PIF_RST;
            r_lat_from <= sidc_pkg::LAT_FROM_PIF_RST;
            r_base     <= '0;
            r_busy     <= 1'b0;
            r_irq      <= 1'b0;
            r_dir      <= 1'b0;
            r_count    <= '0;
        end else begin
            r_lat_to   <= n_lat_to;
            r_lat_from <= n_lat_from;
            r_base     <= n_base;
            r_busy     <= n_busy;
            r_irq      <= n_irq;
            r_dir      <= n_dir;
            r_count    <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sidc_queue.sv -----
// ----------------------------------------------------------------------------
// sidc_queue
// Short job queue between the decode front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sidc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sidc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sidc_pkg::t_job o_head
);

    sidc_pkg::t_job r_mem [sidc_pkg::QUEUE_DEPTH];

    logic [sidc_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [sidc_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [sidc_pkg::QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (sidc_pkg::QPTR_W+1)'(sidc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + sidc_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + sidc_pkg::QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (sidc_pkg::QPTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (sidc_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sidc_back.sv -----
// ----------------------------------------------------------------------------
// sidc_back
// Turns queued jobs into result items: one response, or a byte copy burst.
// ----------------------------------------------------------------------------
`default_nettype none

module sidc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sidc_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic                o_last,
    output sidc_pkg::t_out_data o_data
);

    logic [sidc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                       r_valid, n_valid;
    logic                       r_kind, n_kind;
    logic                       r_last, n_last;
    sidc_pkg::t_out_data        r_data, n_data;

    logic load;
    logic burst_end;

    // The output register takes a new item whenever it is empty or being drained.
    assign load      = !i_empty && (!r_valid || i_ready);
    assign burst_end = (r_idx == sidc_pkg::IDX_W'(sidc_pkg::XFER_BYTES - 1));

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_kind  = r_kind;
        n_last  = r_last;
        n_data  = r_data;
        o_pop   = 1'b0;

        if (load) begin
            n_valid = 1'b1;
            n_data  = '0;
            n_data.irq = i_head.irq;
            if (i_head.burst) begin
                n_kind           = 1'b1;
                n_last           = burst_end;
                n_data.to_pif    = i_head.to_pif;
                n_data.dram_addr = i_head.base + sidc_pkg::DRAM_W'(r_idx);
                n_data.pif_index = sidc_pkg::PIF_W'(r_idx);
                n_data.check     = burst_end && i_head.to_pif;
                if (burst_end) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + sidc_pkg::IDX_W'(1);
                end
            end else begin
                n_kind           = 1'b0;
                n_last           = 1'b1;
                n_data.read_data = i_head.read_data;
                o_pop            = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_last <= n_last;
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_last  = r_last;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hdl/serial_interface_dma_controller.sv -----
// ----------------------------------------------------------------------------
// serial_interface_dma_controller
// Serial interface DMA register block with latency countdown and byte copies.
//
// Channel   Direction  Handshake                  Contents
// s_axis    in         i_s_tvalid / o_s_tready    tuser command, tdata access
// m_axis    out        o_m_tvalid / i_m_tready    tuser kind, tlast, tdata result
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each input item is decoded in the cycle it is accepted; one item per cycle unless the job queue is full.
// A response passes through the job queue and the output register; a completing
// tick yields 64 copy items, one per cycle while i_m_tready holds, paced by the
// back end burst counter. A four-entry job queue parts decode from output; input stalls only when full.
// Reset is synchronous and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_interface_dma_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tuser: command[1:0]
    input  logic [1:0]  i_s_tuser,
    // tdata: address[11:0], write_data[43:12], zero[47:44]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tuser: kind[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    // tdata: read_data[31:0], copy_to_pif[32], dram_byte_address[56:33],
    //        pif_index[62:57], pif_command_check[63], irq[64], zero[71:65]
    output logic [71:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    sidc_pkg::t_job      job;
    sidc_pkg::t_job      head;
    sidc_pkg::t_out_data out_data;

    sidc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_command    (i_s_tuser),
        .i_address    (i_s_tdata[11:0]),
        .i_write_data (i_s_tdata[43:12]),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_job        (job)
    );

    sidc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    sidc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_last  (o_m_tlast),
        .o_data  (out_data)
    );

    assign o_m_tdata = out_data;

endmodule

`default_nettype wire
